// ----- rtl/spaced_run_window_matcher_assert.svh -----
// assertion macros used by the spaced run window matcher checker
`ifndef SPACED_RUN_WINDOW_MATCHER_ASSERT_SVH
`define SPACED_RUN_WINDOW_MATCHER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SRWM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srwm same-cycle check failed");

// next-cycle implication, checked outside reset
`define SRWM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srwm next-cycle check failed");

`endif

// ----- rtl/srwm_pkg.sv -----
// shared constants and types of the spaced run window matcher
`default_nettype none

package srwm_pkg;

    // word field widths
    localparam int SYMBOL_W  = 8;
    localparam int INDEX_W   = 32;
    localparam int PATTERN_W = 64;

    // configuration field widths
    localparam int WLEN_W = 7;
    localparam int GAPS_W = 5;
    localparam int RUN_W  = 6;

    // apb port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // gap position products: gap_count * (run_length + 1)
    localparam int PROD_W = 12;

    // symbol codes
    localparam logic [SYMBOL_W-1:0] GAP_SYMBOL = 8'd32;
    localparam logic [SYMBOL_W-1:0] ONE_SYMBOL = 8'd49;

    // register index codes
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_WLEN = 2'd0;
    localparam reg_idx_t REG_GAPS = 2'd1;
    localparam reg_idx_t REG_RUN  = 2'd2;

    // register reset values
    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd32;
    localparam logic [GAPS_W-1:0] GAPS_RESET = 5'd1;
    localparam logic [RUN_W-1:0]  RUN_RESET  = 6'd5;

    // largest gap count the mask generator covers
    localparam int GAPS_MAX = (1 << GAPS_W) - 1;

endpackage

`default_nettype wire

// ----- rtl/srwm_if.sv -----
// valid/ready channel interfaces for symbol and result words
`default_nettype none

interface srwm_sym_if
    import srwm_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;

    modport source  (output valid, output symbol, input ready);
    modport sink    (input valid, input symbol, output ready);
    modport monitor (input valid, input ready, input symbol);
endinterface

interface srwm_res_if
    import srwm_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [INDEX_W-1:0]   start_index;
    logic [INDEX_W-1:0]   distance;
    logic [PATTERN_W-1:0] ones_pattern;

    modport source  (output valid, output start_index, output distance,
                     output ones_pattern, input ready);
    modport sink    (input valid, input start_index, input distance,
                     input ones_pattern, output ready);
    modport monitor (input valid, input ready, input start_index, input distance,
                     input ones_pattern);
endinterface

`default_nettype wire

// ----- rtl/spaced_run_window_matcher.sv -----
// spaced run window matcher: sliding symbol window with gap mask compare
//
//   channel   dir  handshake          payload
//   symbols   in   valid / ready      symbol[7:0]
//   results   out  valid / ready      start_index[31:0], distance[31:0], ones_pattern[63:0]
//   apb       in   psel/penable/pready paddr[3:0], pwdata[31:0], prdata[31:0]
//
// one symbol word is accepted per cycle unless the input stalls; its result word,
// if any, is loaded into the output register as the compare stage advances; the
// accepting edge shifts the history and loads the compare stage
// reset clears the history, counters and valid flags; no clearing pass is needed
// a stalled result word holds the compare stage, and the input stalls only
// when both the compare stage and the output register are full
`default_nettype none

module spaced_run_window_matcher
    import srwm_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  wire                clk,
    input  wire                rst_n,
    srwm_sym_if.sink           symbols,
    srwm_res_if.source         results,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [ADDR_W-1:0]  paddr,
    input  wire  [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int IDX_W = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;

    // configuration registers
    logic [WLEN_W-1:0] wlen_reg;
    logic [GAPS_W-1:0] gaps_reg;
    logic [RUN_W-1:0]  run_reg;

    // history and counters
    logic [MAX_WINDOW-1:0] gap_hist_reg, gap_hist_next;
    logic [MAX_WINDOW-1:0] one_hist_reg, one_hist_next;
    logic [INDEX_W-1:0]    seen_reg;
    logic [INDEX_W-1:0]    prev_start_reg;

    // compare stage
    logic               s1_valid_reg;
    logic [INDEX_W-1:0] s1_start_reg;
    logic               s1_full_reg;

    // expected gap mask, derived from configuration
    logic [MAX_WINDOW-1:0] mask_reg, mask_next;
    logic                  fit_reg, fit_next;

    // output register
    logic                 out_valid_reg;
    logic [INDEX_W-1:0]   out_start_reg;
    logic [INDEX_W-1:0]   out_dist_reg;
    logic [PATTERN_W-1:0] out_pattern_reg;

    logic [WLEN_W-1:0]     eff_len;
    logic [IDX_W-1:0]      shift_amt;
    logic [MAX_WINDOW-1:0] gap_rev;
    logic [MAX_WINDOW-1:0] one_rev;
    logic [MAX_WINDOW-1:0] win_gap;
    logic [MAX_WINDOW-1:0] win_one;
    logic                  in_fire;
    logic                  s1_adv;
    logic                  match;
    logic                  cfg_wr;
    logic [PROD_W-1:0]     gap_span;

    // handshake
    assign s1_adv         = s1_valid_reg && (!out_valid_reg || results.ready);
    assign symbols.ready  = !s1_valid_reg || s1_adv;
    assign in_fire        = symbols.valid && symbols.ready;
    assign results.valid        = out_valid_reg;
    assign results.start_index  = out_start_reg;
    assign results.distance     = out_dist_reg;
    assign results.ones_pattern = out_pattern_reg;

    // effective window length, clamped into 2..MAX_WINDOW
    always_comb
    begin
        if (wlen_reg < 7'd2)
        begin
            eff_len = 7'd2;
        end
        else if (wlen_reg > WLEN_W'(MAX_WINDOW))
        begin
            eff_len = WLEN_W'(MAX_WINDOW);
        end
        else
        begin
            eff_len = wlen_reg;
        end
    end

    assign shift_amt = IDX_W'(WLEN_W'(MAX_WINDOW) - eff_len);

    // apb access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_WLEN: prdata = DATA_W'(wlen_reg);
            REG_GAPS: prdata = DATA_W'(gaps_reg);
            REG_RUN:  prdata = DATA_W'(run_reg);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WLEN_RESET;
            gaps_reg <= GAPS_RESET;
            run_reg  <= RUN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_WLEN: wlen_reg <= pwdata[WLEN_W-1:0];
                REG_GAPS: gaps_reg <= pwdata[GAPS_W-1:0];
                REG_RUN:  run_reg  <= pwdata[RUN_W-1:0];
                default:  ;
            endcase
        end
    end

    // expected gap positions: k*(run+1)-1 for k = 1..gap_count
    always_comb
    begin
        logic [PROD_W-1:0] pos;
        mask_next = '0;
        for (int k = 1; k <= GAPS_MAX; k++)
        begin
            pos = PROD_W'(k) * PROD_W'({1'b0, run_reg} + 7'd1) - PROD_W'(1);
            if ((GAPS_W'(k) <= gaps_reg) && (pos < PROD_W'(MAX_WINDOW)))
            begin
                mask_next[pos[IDX_W-1:0]] = 1'b1;
            end
        end
    end

    // all gaps fit strictly inside the window and none sits at offset zero
    assign gap_span = PROD_W'(gaps_reg) * PROD_W'({1'b0, run_reg} + 7'd1);
    assign fit_next = (gaps_reg == '0) ||
                      ((run_reg != '0) && (gap_span <= PROD_W'(eff_len - 7'd1)));

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        fit_reg  <= fit_next;
    end

    // history shift on each accepted word
    assign gap_hist_next = {gap_hist_reg[MAX_WINDOW-2:0], symbols.symbol == GAP_SYMBOL};
    assign one_hist_next = {one_hist_reg[MAX_WINDOW-2:0], symbols.symbol == ONE_SYMBOL};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_hist_reg <= '0;
            one_hist_reg <= '0;
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                gap_hist_reg <= gap_hist_next;
                one_hist_reg <= one_hist_next;
                if (seen_reg != '1)
                begin
                    seen_reg <= seen_reg + 32'd1;
                end
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // start index and window-complete flag of the accepted word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_start_reg <= seen_reg - INDEX_W'(eff_len - 7'd1);
            s1_full_reg  <= ({1'b0, seen_reg} + 33'd1) >= 33'(eff_len);
        end
    end

    // window in stream order: bit j is window symbol j
    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            gap_rev[i] = gap_hist_reg[MAX_WINDOW-1-i];
            one_rev[i] = one_hist_reg[MAX_WINDOW-1-i];
        end
    end

    assign win_gap = gap_rev >> shift_amt;
    assign win_one = one_rev >> shift_amt;
    assign match   = s1_full_reg && fit_reg && (win_gap == mask_reg);

    // output register and previous match start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            prev_start_reg <= '0;
        end
        else
        begin
            if (s1_adv && match)
            begin
                out_valid_reg  <= 1'b1;
                prev_start_reg <= s1_start_reg;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && match)
        begin
            out_start_reg   <= s1_start_reg;
            out_dist_reg    <= s1_start_reg - prev_start_reg;
            out_pattern_reg <= PATTERN_W'(win_one);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/srwm_checker.sv -----
// port-level checker for the spaced run window matcher, with its bind
`default_nettype none

`include "spaced_run_window_matcher_assert.svh"

module srwm_checker
    import srwm_pkg::*;
(
    input wire                 clk,
    input wire                 rst_n,
    input wire                 sym_valid,
    input wire                 sym_ready,
    input wire                 res_valid,
    input wire                 res_ready,
    input wire [INDEX_W-1:0]   res_start_index,
    input wire [INDEX_W-1:0]   res_distance,
    input wire [PATTERN_W-1:0] res_ones_pattern
);

    // a new result word follows the acceptance of a symbol word through the compare stage
    `SRWM_ASSERT_SAME(a_res_after_sym, $rose(res_valid), $past(sym_valid && sym_ready, 2))

    // the input side stalls only behind a stalled result word
    `SRWM_ASSERT_SAME(a_stall_chain, !sym_ready, res_valid && !res_ready)

    // a stalled result word holds its payload
    `SRWM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_start_index) && $stable(res_distance) && $stable(res_ones_pattern))

endmodule

bind spaced_run_window_matcher srwm_checker u_srwm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .sym_valid        (symbols.valid),
    .sym_ready        (symbols.ready),
    .res_valid        (results.valid),
    .res_ready        (results.ready),
    .res_start_index  (results.start_index),
    .res_distance     (results.distance),
    .res_ones_pattern (results.ones_pattern)
);

`default_nettype wire
